FILE: src/co2fc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// co2fc_pkg
// Shared types, constants and helper functions of the CO2 frame checker.
// ----------------------------------------------------------------------------
package co2fc_pkg;

    localparam int FRAME_BYTES   = 18;
    localparam int RING_SIZE     = 5;
    localparam int AVG_SHIFT_DEF = 5;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    localparam logic [4:0] POS_CO2_END  = 5'd5;
    localparam logic [4:0] POS_TEMP_END = 5'd11;
    localparam logic [4:0] POS_LAST     = 5'd17;

    localparam logic [1:0] PHASE_CRC = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_CRC  = 2'd1;
    localparam logic [1:0] ST_NAN  = 2'd2;
    localparam logic [1:0] ST_ZERO = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_first;
    } t_request;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic [15:0] co2_median;
        logic [15:0] co2_average;
        logic [31:0] temperature_bits;
        logic [31:0] humidity_bits;
    } t_result;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] ppm;
        logic [31:0] temperature_bits;
        logic [31:0] humidity_bits;
    } t_job;

    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // truncate a finite float to 0..65535
    function automatic logic [15:0] to_ppm(input logic [31:0] bits);
        logic [7:0]  e;
        logic [23:0] m;
        logic [7:0]  sh;
        logic [23:0] q;
        e  = bits[30:23];
        m  = {1'b1, bits[22:0]};
        sh = 8'd150 - e;
        q  = m >> sh[4:0];
        if (bits[31] || e < 8'd127) begin
            return 16'd0;
        end else if (e >= 8'd143) begin
            return 16'hFFFF;
        end
        return q[15:0];
    endfunction

endpackage
`default_nettype wire

FILE: src/co2fc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// co2fc_front
// Byte intake: CRC check, word assembly, error classification per frame.
// ----------------------------------------------------------------------------
module co2fc_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  co2fc_pkg::t_request  i_req,
    output logic                 o_push,
    output co2fc_pkg::t_job      o_job
);

    logic [4:0]  r_pos,   n_pos;
    logic [1:0]  r_phase, n_phase;
    logic [7:0]  r_crc,   n_crc;
    logic [1:0]  r_err,   n_err;
    logic [31:0] r_vshift, n_vshift;
    logic [31:0] r_co2,   n_co2;
    logic [31:0] r_temp,  n_temp;

    logic [4:0]  p;
    logic [1:0]  ph;
    logic [7:0]  crc0;
    logic [1:0]  err0, err1, err2, err3;
    logic        word_end, last;

    always_comb begin
        p    = i_req.frame_first ? 5'd0 : r_pos;
        ph   = i_req.frame_first ? 2'd0 : r_phase;
        crc0 = i_req.frame_first ? co2fc_pkg::CRC_INIT : r_crc;
        err0 = i_req.frame_first ? co2fc_pkg::ST_OK : r_err;

        n_vshift = r_vshift;
        n_co2    = r_co2;
        n_temp   = r_temp;
        if (ph != co2fc_pkg::PHASE_CRC) begin
            n_crc    = co2fc_pkg::crc8_feed(crc0, i_req.rx_byte);
            n_vshift = {r_vshift[23:0], i_req.rx_byte};
            err1     = err0;
        end else begin
            n_crc = co2fc_pkg::CRC_INIT;
            err1  = (crc0 != i_req.rx_byte && err0 == co2fc_pkg::ST_OK) ?
                    co2fc_pkg::ST_CRC : err0;
        end

        word_end = (p == co2fc_pkg::POS_CO2_END) || (p == co2fc_pkg::POS_TEMP_END) ||
                   (p == co2fc_pkg::POS_LAST);
        err2 = (word_end && err1 == co2fc_pkg::ST_OK && r_vshift[30:23] == 8'hFF) ?
               co2fc_pkg::ST_NAN : err1;
        if (p == co2fc_pkg::POS_CO2_END) begin
            n_co2 = r_vshift;
        end
        if (p == co2fc_pkg::POS_TEMP_END) begin
            n_temp = r_vshift;
        end

        last = (p == co2fc_pkg::POS_LAST);
        err3 = (err2 == co2fc_pkg::ST_OK && r_co2[30:0] == 31'd0) ?
               co2fc_pkg::ST_ZERO : err2;

        if (last) begin
            n_pos   = 5'd0;
            n_phase = 2'd0;
            n_crc   = co2fc_pkg::CRC_INIT;
            n_err   = co2fc_pkg::ST_OK;
        end else begin
            n_pos   = p + 5'd1;
            n_phase = (ph == co2fc_pkg::PHASE_CRC) ? 2'd0 : ph + 2'd1;
            n_err   = err2;
        end

        o_push                 = i_accept && last;
        o_job.status           = err3;
        o_job.ppm              = co2fc_pkg::to_ppm(r_co2);
        o_job.temperature_bits = r_temp;
        o_job.humidity_bits    = r_vshift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 5'd0;
            r_phase  <= 2'd0;
            r_crc    <= co2fc_pkg::CRC_INIT;
            r_err    <= co2fc_pkg::ST_OK;
            r_vshift <= 32'd0;
            r_co2    <= 32'd0;
            r_temp   <= 32'd0;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_crc    <= n_crc;
            r_err    <= n_err;
            r_vshift <= n_vshift;
            r_co2    <= n_co2;
            r_temp   <= n_temp;
        end
    end

endmodule
`default_nettype wire

FILE: src/co2fc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// co2fc_queue
// Two-entry queue of frame jobs between the intake and the filter.
// ----------------------------------------------------------------------------
module co2fc_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  co2fc_pkg::t_job  i_job,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_empty,
    output co2fc_pkg::t_job  o_job
);

    co2fc_pkg::t_job r_mem [co2fc_pkg::QUEUE_DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'(co2fc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/co2fc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// co2fc_back
// CO2 filter: ring update, median of five, running average, result register.
// ----------------------------------------------------------------------------
module co2fc_back #(
    parameter int AVG_SHIFT = co2fc_pkg::AVG_SHIFT_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_empty,
    input  co2fc_pkg::t_job     i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output co2fc_pkg::t_result  o_res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RING = 3'd1;
    localparam logic [2:0] S_MED1 = 3'd2;
    localparam logic [2:0] S_MED2 = 3'd3;
    localparam logic [2:0] S_AVG  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    localparam logic [17:0] ROUND = 18'((1 << AVG_SHIFT) - 1);

    logic [2:0]         r_state;
    co2fc_pkg::t_job    r_job;
    logic [15:0]        r_win [co2fc_pkg::RING_SIZE];
    logic [15:0]        r_v   [co2fc_pkg::RING_SIZE];
    logic               r_seeded;
    logic [2:0]         r_slot;
    logic [15:0]        r_avg;
    logic [15:0]        r_med;
    logic               r_out_valid;
    co2fc_pkg::t_result r_out;

    logic [15:0] a0, a1, a2, a3, a4;
    logic [15:0] b0, b1, b3, b4;
    logic [15:0] c1, c2, c3, d1, d2;
    logic [17:0] delta, biased, change;
    logic [15:0] n_avg;
    logic        out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;

    // first two compare layers
    always_comb begin
        a0 = (r_win[0] > r_win[1]) ? r_win[1] : r_win[0];
        a1 = (r_win[0] > r_win[1]) ? r_win[0] : r_win[1];
        a3 = (r_win[3] > r_win[4]) ? r_win[4] : r_win[3];
        a4 = (r_win[3] > r_win[4]) ? r_win[3] : r_win[4];
        a2 = r_win[2];
        b0 = (a0 > a3) ? a3 : a0;
        b3 = (a0 > a3) ? a0 : a3;
        b1 = (a1 > a4) ? a4 : a1;
        b4 = (a1 > a4) ? a1 : a4;
    end

    // last three compare layers
    always_comb begin
        c1 = (r_v[1] > r_v[2]) ? r_v[2] : r_v[1];
        c2 = (r_v[1] > r_v[2]) ? r_v[1] : r_v[2];
        c3 = r_v[3];
        d2 = (c2 > c3) ? c3 : c2;
        d1 = c1;
        if (d1 > d2) begin
            d2 = d1;
        end
    end

    // average step, truncated toward zero
    always_comb begin
        delta  = {2'b00, r_med} - {2'b00, r_avg};
        biased = delta + (delta[17] ? ROUND : 18'd0);
        change = 18'($signed(biased) >>> AVG_SHIFT);
        n_avg  = r_avg + change[15:0];
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_job <= i_job;
            end
            S_MED1: begin
                r_v[0] <= b0;
                r_v[1] <= b1;
                r_v[2] <= a2;
                r_v[3] <= b3;
                r_v[4] <= b4;
            end
            S_MED2: begin
                r_med <= d2;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RING) begin
            for (int i = 0; i < co2fc_pkg::RING_SIZE; i++) begin
                if (!r_seeded || r_slot == 3'(i)) begin
                    r_win[i] <= r_job.ppm;
                end
            end
        end
        if (r_state == S_RING && !r_seeded) begin
            r_avg <= r_job.ppm;
        end else if (r_state == S_AVG) begin
            r_avg <= n_avg;
        end
        if (r_state == S_EMIT && out_free) begin
            r_out.frame_status <= r_job.status;
            if (r_job.status == co2fc_pkg::ST_OK) begin
                r_out.co2_median       <= r_med;
                r_out.co2_average      <= r_avg;
                r_out.temperature_bits <= r_job.temperature_bits;
                r_out.humidity_bits    <= r_job.humidity_bits;
            end else begin
                r_out.co2_median       <= 16'd0;
                r_out.co2_average      <= 16'd0;
                r_out.temperature_bits <= 32'd0;
                r_out.humidity_bits    <= 32'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seeded    <= 1'b0;
            r_slot      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_state <= (i_job.status == co2fc_pkg::ST_OK) ? S_RING : S_EMIT;
                    end
                end
                S_RING: begin
                    if (!r_seeded) begin
                        r_seeded <= 1'b1;
                        r_slot   <= 3'd1;
                    end else begin
                        r_slot <= (r_slot >= 3'(co2fc_pkg::RING_SIZE - 1)) ? 3'd0
                                                                           : r_slot + 3'd1;
                    end
                    r_state <= S_MED1;
                end
                S_MED1: begin
                    r_state <= S_MED2;
                end
                S_MED2: begin
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: src/co2_frame_check_median_average.sv
`default_nettype none
// ----------------------------------------------------------------------------
// co2_frame_check_median_average
// Sensor frame checker with median-of-five and running-average CO2 filter.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle while the job queue has room. Each 18-byte
// frame gives one result after its last byte: frame status, and when the frame is good the
// median of the last five CO2 readings, the running average and the raw
// temperature and humidity bits. The intake checks CRCs and classifies the
// frame as bytes arrive; a two-entry job queue hands finished frames to the
// filter, which runs a good frame through ring write, two median stages,
// average step and result register, and a bad frame straight to the result
// register. The filter stalls only on the result register, and the byte input
// stalls only when the job queue is full.
module co2_frame_check_median_average #(
    parameter int AVG_SHIFT = co2fc_pkg::AVG_SHIFT_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  co2fc_pkg::t_request i_in_req,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output co2fc_pkg::t_result  o_out_res
);

    logic            accept;
    logic            push, pop, full, empty;
    co2fc_pkg::t_job job_in, job_out;

    assign o_in_ready = !full;
    assign accept     = i_in_valid && !full;

    co2fc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_in_req),
        .o_push   (push),
        .o_job    (job_in)
    );

    co2fc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (job_out)
    );

    co2fc_back #(
        .AVG_SHIFT (AVG_SHIFT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (o_out_res)
    );

endmodule
`default_nettype wire

FILE: tb/sv/tb_co2_frame_check_median_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_co2_frame_check_median_average
// Self-checking bench for the CO2 frame checker with median and average filter.
// ----------------------------------------------------------------------------
// Builds 18-byte sensor frames with correct or damaged CRCs and feeds them one
// byte per request, together with truncated frames and stray bytes. A local
// model of the checker tracks frame position, CRC, error order, the median
// ring and the running average, and every returned result is compared field
// by field with the oldest predicted one. Both handshakes are paced through
// several idle and stall mixes, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_co2_frame_check_median_average;

    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_BYTES = 290;
    localparam logic [31:0] TEMP_25 = 32'h41C80000;
    localparam logic [31:0] HUM_50  = 32'h42480000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    co2fc_pkg::t_request i_in_req;
    logic                o_out_valid;
    logic                i_out_ready;
    co2fc_pkg::t_result  o_out_res;

    co2fc_pkg::t_request pending_bytes[$];
    co2fc_pkg::t_result  results_due[$];

    // model state
    int          frame_pos;
    logic [7:0]  crc_acc;
    logic [31:0] word_shift;
    logic [31:0] co2_bits;
    logic [31:0] temp_bits;
    logic [1:0]  err_code;
    logic [15:0] ring [co2fc_pkg::RING_SIZE];
    bit          ring_seeded;
    int          ring_slot;
    logic [15:0] avg_ppm;

    int send_idle_pct;
    int recv_stall_pct;
    bit req_taken;
    bit hold_req;
    bit hold_done;
    int hold_count;
    int quiet_cycles;
    int bytes_sent;
    int results_checked;
    int mismatches;
    int status_seen [4];

    co2_frame_check_median_average dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0} ^ (fb ? co2fc_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic logic [15:0] float_to_ppm(input logic [31:0] f);
        int unsigned ex;
        logic [23:0] mant;
        ex   = f[30:23];
        mant = {1'b1, f[22:0]};
        if (f[31] || ex < 127) return 16'd0;
        if (ex > 142) return 16'hFFFF;
        return 16'(mant >> (150 - ex));
    endfunction

    // exact float bits of a whole number below 2^16
    function automatic logic [31:0] ppm_float(input int unsigned v);
        int          n;
        logic [31:0] shifted;
        if (v == 0) return 32'h0;
        n = 0;
        for (int i = 0; i < 17; i++) begin
            if (v >> i != 0) n = i;
        end
        shifted = v << (23 - n);
        return {1'b0, 8'(127 + n), shifted[22:0]};
    endfunction

    function automatic logic [31:0] random_co2_bits();
        int r;
        r = $urandom_range(99);
        if (r < 60) return {1'b0, 8'($urandom_range(135, 139)), 23'($urandom)};
        if (r < 70) return {1'b0, 8'($urandom_range(127, 142)), 23'($urandom)};
        if (r < 75) return {1'b0, 8'($urandom_range(143, 254)), 23'($urandom)};
        if (r < 80) return {1'b0, 8'($urandom_range(0, 126)), 23'($urandom)};
        if (r < 85) return {1'b1, 8'($urandom_range(0, 254)), 23'($urandom)};
        if (r < 90) return {1'($urandom_range(1)), 31'h0};
        if (r < 95) return {1'($urandom_range(1)), 8'hFF, 23'($urandom)};
        return $urandom;
    endfunction

    function automatic logic [31:0] random_word_bits();
        if ($urandom_range(99) < 95) begin
            return {1'($urandom_range(1)), 8'($urandom_range(0, 254)), 23'($urandom)};
        end
        return $urandom;
    endfunction

    task automatic queue_frame(input logic [31:0] co2, input logic [31:0] temp,
                               input logic [31:0] hum, input bit mark, input int bad_byte);
        logic [95:0]         words;
        logic [15:0]         w;
        logic [7:0]          frame [co2fc_pkg::FRAME_BYTES];
        co2fc_pkg::t_request req;
        words = {co2, temp, hum};
        for (int k = 0; k < 6; k++) begin
            w              = words[95 - 16 * k -: 16];
            frame[3 * k]     = w[15:8];
            frame[3 * k + 1] = w[7:0];
            frame[3 * k + 2] = crc_next(crc_next(co2fc_pkg::CRC_INIT, w[15:8]), w[7:0]);
        end
        if (bad_byte >= 0) begin
            frame[bad_byte] = frame[bad_byte] ^ 8'($urandom_range(1, 255));
        end
        for (int k = 0; k < co2fc_pkg::FRAME_BYTES; k++) begin
            req.rx_byte     = frame[k];
            req.frame_first = (k == 0) && mark;
            pending_bytes.push_back(req);
        end
    endtask

    task automatic queue_random_traffic(input int n_bytes);
        int                  target;
        int                  r;
        int                  cut;
        bit                  need_mark;
        co2fc_pkg::t_request req;
        target    = pending_bytes.size() + n_bytes;
        need_mark = 1'b1;
        while (pending_bytes.size() < target) begin
            r = $urandom_range(99);
            if (r < 80) begin
                queue_frame(random_co2_bits(), random_word_bits(), random_word_bits(),
                            need_mark || 1'($urandom_range(1)),
                            ($urandom_range(99) < 12) ? int'($urandom_range(17)) : -1);
                need_mark = 1'b0;
            end else if (r < 90) begin
                // truncated frame, dropped by the next mark
                queue_frame(random_co2_bits(), random_word_bits(), random_word_bits(),
                            1'($urandom_range(1)), -1);
                cut = $urandom_range(1, co2fc_pkg::FRAME_BYTES - 1);
                repeat (cut) void'(pending_bytes.pop_back());
                need_mark = 1'b1;
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    req.rx_byte     = 8'($urandom);
                    req.frame_first = ($urandom_range(9) == 0);
                    pending_bytes.push_back(req);
                end
                need_mark = 1'b1;
            end
        end
    endtask

    task automatic absorb_frame_byte(input co2fc_pkg::t_request req);
        int                 p;
        logic [31:0]        hum;
        logic [15:0]        ppm;
        logic [15:0]        s [co2fc_pkg::RING_SIZE];
        logic [15:0]        tmp;
        int                 step;
        co2fc_pkg::t_result res;
        p = frame_pos;
        if (req.frame_first) begin
            p        = 0;
            crc_acc  = co2fc_pkg::CRC_INIT;
            err_code = co2fc_pkg::ST_OK;
        end
        if (p >= co2fc_pkg::FRAME_BYTES) p = 0;

        if (p % 3 != 2) begin
            crc_acc    = crc_next(crc_acc, req.rx_byte);
            word_shift = {word_shift[23:0], req.rx_byte};
        end else begin
            if (crc_acc != req.rx_byte && err_code == co2fc_pkg::ST_OK) begin
                err_code = co2fc_pkg::ST_CRC;
            end
            crc_acc = co2fc_pkg::CRC_INIT;
        end

        if (p == co2fc_pkg::POS_CO2_END || p == co2fc_pkg::POS_TEMP_END ||
            p == co2fc_pkg::POS_LAST) begin
            if (err_code == co2fc_pkg::ST_OK && word_shift[30:23] == 8'hFF) begin
                err_code = co2fc_pkg::ST_NAN;
            end
            if (p == co2fc_pkg::POS_CO2_END) co2_bits = word_shift;
            if (p == co2fc_pkg::POS_TEMP_END) temp_bits = word_shift;
        end

        if (p != co2fc_pkg::POS_LAST) begin
            frame_pos = p + 1;
            return;
        end

        hum = word_shift;
        if (err_code == co2fc_pkg::ST_OK && co2_bits[30:0] == 31'h0) begin
            err_code = co2fc_pkg::ST_ZERO;
        end
        frame_pos = 0;
        crc_acc   = co2fc_pkg::CRC_INIT;
        res       = '0;
        res.frame_status = err_code;
        status_seen[err_code]++;

        if (err_code != co2fc_pkg::ST_OK) begin
            results_due.push_back(res);
            err_code = co2fc_pkg::ST_OK;
            return;
        end

        ppm = float_to_ppm(co2_bits);
        if (!ring_seeded) begin
            for (int k = 0; k < co2fc_pkg::RING_SIZE; k++) ring[k] = ppm;
            avg_ppm     = ppm;
            ring_slot   = 1;
            ring_seeded = 1'b1;
        end else begin
            if (ring_slot >= co2fc_pkg::RING_SIZE) ring_slot = 0;
            ring[ring_slot] = ppm;
            ring_slot = (ring_slot == co2fc_pkg::RING_SIZE - 1) ? 0 : ring_slot + 1;
        end

        for (int k = 0; k < co2fc_pkg::RING_SIZE; k++) s[k] = ring[k];
        for (int i = 1; i < co2fc_pkg::RING_SIZE; i++) begin
            for (int j = i; j > 0 && s[j - 1] > s[j]; j--) begin
                tmp      = s[j];
                s[j]     = s[j - 1];
                s[j - 1] = tmp;
            end
        end

        step    = (int'(s[2]) - int'(avg_ppm)) / (1 << co2fc_pkg::AVG_SHIFT_DEF);
        avg_ppm = 16'(int'(avg_ppm) + step);

        res.co2_median       = s[2];
        res.co2_average      = avg_ppm;
        res.temperature_bits = temp_bits;
        res.humidity_bits    = hum;
        results_due.push_back(res);
    endtask

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        mismatches++;
        $display("%0t: %s expected %h got %h", $time, field, want, got);
    endtask

    task automatic check_result(input co2fc_pkg::t_result want,
                                input co2fc_pkg::t_result got);
        if (want.frame_status !== got.frame_status)
            report_field("frame_status", 32'(want.frame_status), 32'(got.frame_status));
        if (want.co2_median !== got.co2_median)
            report_field("co2_median", 32'(want.co2_median), 32'(got.co2_median));
        if (want.co2_average !== got.co2_average)
            report_field("co2_average", 32'(want.co2_average), 32'(got.co2_average));
        if (want.temperature_bits !== got.temperature_bits)
            report_field("temperature_bits", want.temperature_bits, got.temperature_bits);
        if (want.humidity_bits !== got.humidity_bits)
            report_field("humidity_bits", want.humidity_bits, got.humidity_bits);
    endtask

    task automatic wait_all_done();
        while (pending_bytes.size() != 0 || i_in_valid || results_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // request driver
    always @(negedge i_clk) begin
        co2fc_pkg::t_request next_req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_req   <= '0;
        end else if (!i_in_valid || req_taken) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = pending_bytes.pop_front();
                i_in_valid <= 1'b1;
                i_in_req   <= next_req;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            i_out_ready <= 1'b0;
            if (hold_count == HOLD_CYCLES) begin
                hold_done <= 1'b1;
            end else begin
                hold_count <= hold_count + 1;
            end
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor, model update and watchdog
    always @(posedge i_clk) begin
        co2fc_pkg::t_result want;
        if (!i_rst_n) begin
            req_taken   <= 1'b0;
            frame_pos   = 0;
            crc_acc     = co2fc_pkg::CRC_INIT;
            word_shift  = '0;
            co2_bits    = '0;
            temp_bits   = '0;
            err_code    = co2fc_pkg::ST_OK;
            ring_seeded = 1'b0;
            ring_slot   = 0;
            avg_ppm     = '0;
            for (int k = 0; k < co2fc_pkg::RING_SIZE; k++) ring[k] = '0;
        end else begin
            req_taken <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result expected none got %h", $time, o_out_res);
                end else begin
                    want = results_due.pop_front();
                    check_result(want, o_out_res);
                end
                results_checked++;
            end
            if (i_in_valid && o_in_ready) begin
                absorb_frame_byte(i_in_req);
                bytes_sent++;
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: timeout with %0d results outstanding", $time,
                         results_due.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        hold_req       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames
        queue_frame(ppm_float(400), TEMP_25, HUM_50, 1'b1, -1);
        queue_frame(32'h477FFFFF, 32'h00000000, 32'hFF7FFFFF, 1'b0, -1);
        queue_frame(32'h64000000, 32'h7F7FFFFF, 32'h80000000, 1'b1, -1);
        queue_frame(32'h32000000, TEMP_25, HUM_50, 1'b0, -1);
        queue_frame(32'h00000001, TEMP_25, HUM_50, 1'b0, -1);
        queue_frame(32'hC0A00000, TEMP_25, HUM_50, 1'b1, -1);
        queue_frame(32'h00000000, TEMP_25, HUM_50, 1'b0, -1);
        queue_frame(32'h80000000, TEMP_25, HUM_50, 1'b0, -1);
        queue_frame(32'h7FC00000, TEMP_25, HUM_50, 1'b0, -1);
        queue_frame(ppm_float(800), TEMP_25, 32'h7F800000, 1'b0, -1);
        queue_frame(ppm_float(800), TEMP_25, HUM_50, 1'b0, 2);
        queue_frame(32'h7F800000, TEMP_25, HUM_50, 1'b0, 2);
        queue_frame(32'h7F800000, TEMP_25, HUM_50, 1'b0, 8);
        queue_frame(32'h00000000, TEMP_25, HUM_50, 1'b0, 17);
        queue_frame(ppm_float(1000), TEMP_25, HUM_50, 1'b1, -1);
        repeat (11) void'(pending_bytes.pop_back());
        queue_frame(ppm_float(1), TEMP_25, HUM_50, 1'b1, -1);
        queue_frame(ppm_float(65535), 32'hFFFFFFFF & 32'h7F7FFFFF, HUM_50, 1'b0, -1);
        wait_all_done();

        // long output hold-off while requests keep coming
        repeat (6) begin
            queue_frame(random_co2_bits(), random_word_bits(), random_word_bits(), 1'b0, -1);
        end
        hold_req = 1'b1;
        while (!hold_done) @(posedge i_clk);
        hold_req = 1'b0;
        wait_all_done();

        for (int ph = 0; ph < 4; ph++) begin
            unique case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            queue_random_traffic(PHASE_BYTES);
            wait_all_done();
        end

        repeat (40) @(posedge i_clk);
        $display("sent %0d frame bytes, checked %0d results", bytes_sent, results_checked);
        $display("status mix: %0d good, %0d crc, %0d nan, %0d zero; four pacing mixes",
                 status_seen[co2fc_pkg::ST_OK], status_seen[co2fc_pkg::ST_CRC],
                 status_seen[co2fc_pkg::ST_NAN], status_seen[co2fc_pkg::ST_ZERO]);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
